### rtl/rc5_pkg.sv
// Shared types and constants for the RC5-64 encrypt core.
package rc5_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned RotW  = 6;

  localparam logic [WordW-1:0] MagicP = 64'hB7E151628AED2A6B;
  localparam logic [WordW-1:0] MagicQ = 64'h9E3779B97F4A7C15;
  localparam logic [RotW-1:0]  KeyRot = 6'd3;

  typedef enum logic {
    OP_EXPAND  = 1'b0,
    OP_ENCRYPT = 1'b1
  } rc5_op_e;

  typedef enum logic {
    ALU_ADD_ROTL,
    ALU_XOR_ROTL_ADD
  } rc5_alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_A,
    ST_MIX_B,
    ST_ENC,
    ST_DONE
  } rc5_state_e;

  typedef struct packed {
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] word_a;
    rc5_op_e          opcode;
  } rc5_request_t;

  typedef struct packed {
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] word_a;
    logic             key_ready;
  } rc5_result_t;

endpackage

### rtl/rc5_alu.sv
// Shared RC5 arithmetic unit: add/xor, rotate-left, add.
module rc5_alu import rc5_pkg::*; (
  input  rc5_alu_op_e      op_i,
  input  logic [WordW-1:0] p_i,
  input  logic [WordW-1:0] q_i,
  input  logic [WordW-1:0] r_i,
  input  logic [RotW-1:0]  s_i,
  output logic [WordW-1:0] y_o
);

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [RotW-1:0]  s);
    rotl = (x << s) | (x >> ((RotW+1)'(WordW) - {1'b0, s}));
  endfunction

  logic [WordW-1:0] sum3;
  logic [WordW-1:0] xr;

  always_comb begin
    sum3 = p_i + q_i + r_i;
    xr   = p_i ^ q_i;
    unique case (op_i)
      ALU_ADD_ROTL:     y_o = rotl(sum3, s_i);
      ALU_XOR_ROTL_ADD: y_o = rotl(xr, s_i) + r_i;
      default:          y_o = '0;
    endcase
  end

endmodule

### rtl/rc5_core.sv
// RC5 sequencer: round-key table memory, key schedule and encrypt loop.
module rc5_core import rc5_pkg::*; #(
  parameter int unsigned ROUNDS    = 12,
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  rc5_request_t     req_i,
  output logic             req_ready_o,
  input  logic [WordW-1:0] key_low_i,
  input  logic [WordW-1:0] key_high_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output rc5_result_t      res_o
);

  function automatic logic [WordW-1:0] key_mask(input int unsigned nbytes);
    logic [WordW-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < WordW / 8; i++) begin
      if (i < nbytes) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam int unsigned TableWords = 2 * ROUNDS + 2;
  localparam int unsigned KeyWords   = (KEY_BYTES + 7) / 8;
  localparam int unsigned AddrW      = $clog2(TableWords);
  localparam int unsigned Steps      = 3 * ((TableWords > KeyWords) ? TableWords : KeyWords);
  localparam int unsigned StepW      = $clog2(Steps);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TableWords - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);
  localparam logic             LastKey  = 1'(KeyWords - 1);
  localparam logic [WordW-1:0] KeyMask0 = key_mask((KEY_BYTES > 8) ? 8 : KEY_BYTES);
  localparam logic [WordW-1:0] KeyMask1 = key_mask((KEY_BYTES > 8) ? KEY_BYTES - 8 : 0);

  rc5_state_e       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [StepW-1:0] step_q, step_d;
  logic             k_q, k_d;
  logic [WordW-1:0] a_q, a_d;
  logic [WordW-1:0] b_q, b_d;
  logic [WordW-1:0] lw_q [2];
  logic [WordW-1:0] lw_d [2];
  rc5_op_e          op_q, op_d;
  logic             table_valid_q, table_valid_d;

  logic [WordW-1:0] table_mem [TableWords];
  logic [WordW-1:0] rd_data_q;
  logic             mem_we;

  rc5_alu_op_e      alu_op;
  logic [WordW-1:0] alu_p, alu_q, alu_r, alu_y;
  logic [RotW-1:0]  alu_s;

  logic             req_take;
  logic             idx_last;
  logic             step_last;

  assign req_take  = req_valid_i && (state_q == ST_IDLE);
  assign idx_last  = (idx_q == LastAddr);
  assign step_last = (step_q == LastStep);

  rc5_alu u_alu (
    .op_i (alu_op),
    .p_i  (alu_p),
    .q_i  (alu_q),
    .r_i  (alu_r),
    .s_i  (alu_s),
    .y_o  (alu_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_take) state_d = (req_i.opcode == OP_EXPAND) ? ST_INIT : ST_ENC;
      end
      ST_INIT: begin
        if (idx_last) state_d = ST_MIX_A;
      end
      ST_MIX_A: state_d = ST_MIX_B;
      ST_MIX_B: state_d = step_last ? ST_DONE : ST_MIX_A;
      ST_ENC: begin
        if (idx_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d         = idx_q;
    step_d        = step_q;
    k_d           = k_q;
    a_d           = a_q;
    b_d           = b_q;
    lw_d          = lw_q;
    op_d          = op_q;
    table_valid_d = table_valid_q;
    mem_we        = 1'b0;
    alu_op        = ALU_ADD_ROTL;
    alu_p         = a_q;
    alu_q         = '0;
    alu_r         = '0;
    alu_s         = '0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (req_take) begin
          op_d   = req_i.opcode;
          step_d = '0;
          k_d    = 1'b0;
          if (req_i.opcode == OP_EXPAND) begin
            a_d      = MagicP;
            b_d      = '0;
            lw_d[0]  = key_low_i & KeyMask0;
            lw_d[1]  = key_high_i & KeyMask1;
          end else begin
            a_d = req_i.word_a;
            b_d = req_i.word_b;
          end
        end
      end
      ST_INIT: begin
        // seed table: S[i] = P + i*Q, a_q carries the running value
        alu_q  = MagicQ;
        mem_we = 1'b1;
        if (idx_last) begin
          idx_d = '0;
          a_d   = '0;
        end else begin
          idx_d = idx_q + AddrW'(1);
          a_d   = alu_y;
        end
      end
      ST_MIX_A: begin
        alu_p  = rd_data_q;
        alu_q  = a_q;
        alu_r  = b_q;
        alu_s  = KeyRot;
        mem_we = 1'b1;
        a_d    = alu_y;
      end
      ST_MIX_B: begin
        alu_p     = lw_q[k_q];
        alu_q     = a_q;
        alu_r     = b_q;
        alu_s     = a_q[RotW-1:0] + b_q[RotW-1:0];
        b_d       = alu_y;
        lw_d[k_q] = alu_y;
        idx_d     = idx_last ? '0 : idx_q + AddrW'(1);
        k_d       = (k_q == LastKey) ? 1'b0 : ~k_q;
        step_d    = step_q + StepW'(1);
        if (step_last) table_valid_d = 1'b1;
      end
      ST_ENC: begin
        if (idx_q < AddrW'(2)) begin
          alu_p = idx_q[0] ? b_q : a_q;
          alu_q = rd_data_q;
        end else begin
          alu_op = ALU_XOR_ROTL_ADD;
          alu_p  = idx_q[0] ? b_q : a_q;
          alu_q  = idx_q[0] ? a_q : b_q;
          alu_r  = rd_data_q;
          alu_s  = idx_q[0] ? a_q[RotW-1:0] : b_q[RotW-1:0];
        end
        if (idx_q[0]) b_d = alu_y;
        else          a_d = alu_y;
        idx_d = idx_last ? '0 : idx_q + AddrW'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // round-key table, registered read one step ahead
  always_ff @(posedge clk_i) begin
    if (mem_we) table_mem[idx_q] <= (state_q == ST_INIT) ? a_q : alu_y;
    rd_data_q <= table_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      step_q        <= '0;
      k_q           <= 1'b0;
      table_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      step_q        <= step_d;
      k_q           <= k_d;
      table_valid_q <= table_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    lw_q  <= lw_d;
    op_q  <= op_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    if (op_q == OP_EXPAND) begin
      res_o.word_a    = '0;
      res_o.word_b    = '0;
      res_o.key_ready = 1'b1;
    end else begin
      res_o.word_a    = a_q;
      res_o.word_b    = b_q;
      res_o.key_ready = table_valid_q;
    end
  end

  a_valid_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_valid_q |=> table_valid_q)
    else $error("round table valid flag dropped");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (idx_q <= LastAddr))
    else $error("table index out of range");

  a_key_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX_B) |-> (k_q <= LastKey))
    else $error("key word index out of range");

  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_take_i) |=> (res_valid_o && $stable(a_q) && $stable(b_q)))
    else $error("pending result changed before it was taken");

  a_expand_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (op_q == OP_EXPAND)) |-> table_valid_q)
    else $error("expansion finished without marking the table valid");

endmodule

### rtl/rc5_64_block_encrypt_core.sv
// RC5-64 encrypt core top level: stream ports, APB key registers, result register.
//
// Usage: write the key over APB (key bytes 0..7 at address 0x0, bytes 8..15 at 0x8,
// little-endian), then send an expand request (s_axis_tuser = 0) before any encrypt
// request (s_axis_tuser = 1). Key writes take effect at the next expand request.
// s_axis_tdata carries plaintext A in bits 63:0 and B in bits 127:64; m_axis_tdata
// returns ciphertext the same way (zero for an expand request) and m_axis_tuser the
// key-ready flag. Every request gives exactly one result.
// The round-key table holds T = 2*ROUNDS+2 words. An encrypt request runs one half-round
// per cycle through the shared add/xor/rotate unit, paced by the one read port of the
// round-key memory. An expand request seeds all T table words, then mixes the key in
// with two unit passes per step. s_axis_tready is low while a request is in progress.
// The result register lets the next request start while a result is still waiting;
// if the receiver stalls until the next result is finished too, the core holds its
// finished result and stays busy until the register frees. Reset clears the key
// registers, the key-ready flag and both valid flags; the round-key table holds no
// value until an expand request has run.
module rc5_64_block_encrypt_core import rc5_pkg::*; #(
  parameter int unsigned ROUNDS    = 12,
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // word_a_in[63:0], word_b_in[127:64]
  input  logic [0:0]   s_axis_tuser,   // opcode[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // word_a_out[63:0], word_b_out[127:64]
  output logic [0:0]   m_axis_tuser,   // key_ready[0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  logic [WordW-1:0] key_low_q, key_high_q;
  logic             cfg_we;

  rc5_request_t     req;
  logic             res_valid;
  logic             res_take;
  rc5_result_t      res;

  logic             out_valid_q;
  rc5_result_t      out_res_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3])
        RegKeyLow:  key_low_q  <= pwdata;
        RegKeyHigh: key_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      RegKeyLow:  prdata = key_low_q;
      RegKeyHigh: prdata = key_high_q;
      default:    prdata = '0;
    endcase
  end

  assign req.word_a = s_axis_tdata[63:0];
  assign req.word_b = s_axis_tdata[127:64];
  assign req.opcode = rc5_op_e'(s_axis_tuser[0]);

  rc5_core #(
    .ROUNDS    (ROUNDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_res_q <= res;
  end

  assign m_axis_tvalid        = out_valid_q;
  assign m_axis_tdata[63:0]   = out_res_q.word_a;
  assign m_axis_tdata[127:64] = out_res_q.word_b;
  assign m_axis_tuser[0]      = out_res_q.key_ready;

endmodule

### test/rc5_64_block_encrypt_core_tb.sv
// Testbench for the RC5-64 encrypt core: key expansion and block encryption checked against a local cipher model.
module rc5_64_block_encrypt_core_tb;
  import rc5_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS     = 12;
  localparam int unsigned KEY_BYTES  = 16;
  localparam int unsigned TableWords = 2 * ROUNDS + 2;
  localparam int unsigned KeyWords   = (KEY_BYTES + 7) / 8;
  localparam int          KeyLowIdx  = 0;
  localparam int          KeyHighIdx = 1;
  localparam logic [63:0] AllOnes    = '1;
  localparam int          HoldCycles = 400;
  localparam int          PhaseItems = 86;

  typedef struct {
    rc5_op_e     op;
    logic [63:0] word_a;
    logic [63:0] word_b;
  } cipher_req_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // word_a_in[63:0], word_b_in[127:64]
  logic [0:0]   s_axis_tuser = '0;   // opcode[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // word_a_out[63:0], word_b_out[127:64]
  logic [0:0]   m_axis_tuser;        // key_ready[0]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  cipher_req_t  pending_requests[$];
  rc5_result_t  expected_blocks[$];
  cipher_req_t  cur_req;
  logic [63:0]  key_lo_shadow = '0;
  logic [63:0]  key_hi_shadow = '0;
  logic [63:0]  sched_keys[TableWords] = '{default: '0};
  logic         table_loaded = 1'b0;
  int           idle_pct = 12;
  bit           hold_armed = 1'b0;
  int           hold_left = 0;
  int           errors = 0;

  rc5_64_block_encrypt_core #(
    .ROUNDS   (ROUNDS),
    .KEY_BYTES(KEY_BYTES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [63:0] rotl_word(input logic [63:0] v, input logic [5:0] s);
    if (s == 6'd0) begin
      return v;
    end
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic void expand_schedule();
    logic [63:0] kw[2];
    logic [63:0] src;
    logic [63:0] x;
    logic [63:0] y;
    int          j;
    int          k;
    int          steps;
    kw[0] = '0;
    kw[1] = '0;
    for (int i = 0; i < KEY_BYTES && i < 16; i++) begin
      src = (i < 8) ? key_lo_shadow : key_hi_shadow;
      kw[i / 8][8 * (i % 8) +: 8] = src[8 * (i % 8) +: 8];
    end
    sched_keys[0] = MagicP;
    for (int i = 1; i < TableWords; i++) begin
      sched_keys[i] = sched_keys[i - 1] + MagicQ;
    end
    steps = 3 * ((TableWords > KeyWords) ? TableWords : KeyWords);
    x = '0;
    y = '0;
    j = 0;
    k = 0;
    for (int i = 0; i < steps; i++) begin
      x = rotl_word(sched_keys[j] + x + y, KeyRot);
      sched_keys[j] = x;
      y = rotl_word(kw[k] + x + y, 6'(x + y));
      kw[k] = y;
      j = (j + 1) % TableWords;
      k = (k + 1) % KeyWords;
    end
    table_loaded = 1'b1;
  endfunction

  function automatic rc5_result_t encrypt_block(input logic [63:0] a_in, input logic [63:0] b_in);
    rc5_result_t res;
    logic [63:0] a;
    logic [63:0] b;
    a = a_in + sched_keys[0];
    b = b_in + sched_keys[1];
    for (int r = 1; r <= ROUNDS; r++) begin
      a = rotl_word(a ^ b, b[5:0]) + sched_keys[2 * r];
      b = rotl_word(b ^ a, a[5:0]) + sched_keys[2 * r + 1];
    end
    res.word_a = a;
    res.word_b = b;
    res.key_ready = table_loaded;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(9))
      0: begin
        w = '0;
      end
      1: begin
        w = AllOnes;
      end
      2: begin
        w = 64'd1 << $urandom_range(63);
      end
      default: begin
        w = {$urandom, $urandom};
      end
    endcase
    return w;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    rc5_result_t predicted;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_req.op == OP_EXPAND) begin
          expand_schedule();
          predicted = '0;
          predicted.key_ready = 1'b1;
        end else begin
          predicted = encrypt_block(cur_req.word_a, cur_req.word_b);
        end
        expected_blocks.push_back(predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.word_b, cur_req.word_a};
          s_axis_tuser  <= cur_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rc5_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result a=%h b=%h key_ready=%b", $time,
                   m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser[0]);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (m_axis_tdata[63:0] !== want.word_a) begin
            $display("%0t: word_a expected %h actual %h", $time, want.word_a,
                     m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== want.word_b) begin
            $display("%0t: word_b expected %h actual %h", $time, want.word_b,
                     m_axis_tdata[127:64]);
            errors++;
          end
          if (m_axis_tuser[0] !== want.key_ready) begin
            $display("%0t: key_ready expected %b actual %b", $time, want.key_ready,
                     m_axis_tuser[0]);
            errors++;
          end
        end
      end
      if (hold_armed && m_axis_tvalid) begin
        hold_armed = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic push_req(input rc5_op_e op, input logic [63:0] a, input logic [63:0] b);
    cipher_req_t req;
    req.op = op;
    req.word_a = a;
    req.word_b = b;
    pending_requests.push_back(req);
  endtask

  task automatic write_key(input int idx, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == KeyLowIdx) begin
      key_lo_shadow = val;
    end else begin
      key_hi_shadow = val;
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_blocks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #6ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key (all zero), expand with junk data, then edge-case blocks
    push_req(OP_EXPAND, AllOnes, AllOnes);
    push_req(OP_ENCRYPT, '0, '0);
    push_req(OP_ENCRYPT, AllOnes, AllOnes);
    push_req(OP_ENCRYPT, AllOnes, '0);
    push_req(OP_ENCRYPT, '0, AllOnes);
    push_req(OP_ENCRYPT, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    push_req(OP_ENCRYPT, 64'd1, 64'h8000000000000000);
    wait_drained();

    // new key must not affect encryption until the next expand
    write_key(KeyLowIdx, AllOnes);
    write_key(KeyHighIdx, AllOnes);
    push_req(OP_ENCRYPT, '0, '0);
    push_req(OP_EXPAND, '0, '0);
    push_req(OP_ENCRYPT, '0, '0);
    push_req(OP_ENCRYPT, AllOnes, AllOnes);
    wait_drained();

    write_key(KeyLowIdx, 64'h0706050403020100);
    write_key(KeyHighIdx, 64'h0F0E0D0C0B0A0908);
    push_req(OP_EXPAND, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    push_req(OP_ENCRYPT, 64'h0011223344556677, 64'h8899AABBCCDDEEFF);
    push_req(OP_EXPAND, '0, '0);
    push_req(OP_ENCRYPT, 64'hDEADBEEFCAFEF00D, 64'h0F1E2D3C4B5A6978);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 2) ? 0 : 12;
      case (ph)
        0: begin
          write_key(KeyLowIdx, '0);
          write_key(KeyHighIdx, AllOnes);
        end
        1: begin
          write_key(KeyLowIdx, AllOnes);
          write_key(KeyHighIdx, '0);
        end
        default: begin
          write_key(KeyLowIdx, rand_word());
          write_key(KeyHighIdx, rand_word());
        end
      endcase
      if (ph == 4) begin
        hold_armed = 1'b1;
      end
      if ($urandom_range(1) == 0) begin
        push_req(OP_EXPAND, rand_word(), rand_word());
      end
      for (int n = 0; n < PhaseItems; n++) begin
        push_req(($urandom_range(99) < 4) ? OP_EXPAND : OP_ENCRYPT, rand_word(), rand_word());
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/rc5_pkg.sv
rtl/rc5_alu.sv
rtl/rc5_core.sv
rtl/rc5_64_block_encrypt_core.sv
test/rc5_64_block_encrypt_core_tb.sv
